>>> src/lcec_pkg.sv
// shared types and constants of the lane crossing event classifier
`default_nettype none

package lcec_pkg;

    // fixed widths of the configuration registers
    localparam int TOL_BITS   = 16;
    localparam int WIN_BITS   = 32;
    localparam int SCALE_BITS = 9;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    // effective persist window: (window * scale) >> 8
    localparam int CONF_BITS  = WIN_BITS + SCALE_BITS - 8;
    // result item: crossing_active, event_code, padded to a byte
    localparam int EVENT_BITS = 3;
    localparam int OUT_W      = 8;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERSIST   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CROSS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OBJ_MEM   = 3'd5;

    // reset values of the registers and of the derived products
    localparam logic [TOL_BITS-1:0]   TOL_RESET       = 16'd100;
    localparam logic [WIN_BITS-1:0]   TOL_SQ_RESET    = 32'd10000;
    localparam logic [WIN_BITS-1:0]   PERSIST_RESET   = 32'd500;
    localparam logic [SCALE_BITS-1:0] SCALE_RESET     = 9'd128;
    localparam logic [CONF_BITS-1:0]  PERSIST_C_RESET = 33'd250;
    localparam logic [WIN_BITS-1:0]   SETTLE_RESET    = 32'd1000;
    localparam logic [WIN_BITS-1:0]   MAX_CROSS_RESET = 32'd10000;
    localparam logic [WIN_BITS-1:0]   OBJ_MEM_RESET   = 32'd2000;

    // turn indicator codes
    localparam logic [1:0] BLINK_NONE  = 2'd0;
    localparam logic [1:0] BLINK_OFF   = 2'd1;
    localparam logic [1:0] BLINK_LEFT  = 2'd2;
    localparam logic [1:0] BLINK_RIGHT = 2'd3;

    typedef enum logic [EVENT_BITS-1:0] {
        EV_NONE     = 3'd0,
        EV_ONSET    = 3'd1,
        EV_ABANDON  = 3'd2,
        EV_RETURNED = 3'd3,
        EV_BACKSTOP = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'b01,
        PH_CROSS = 2'b10
    } phase_t;

    // configuration as seen by the classifier, with precomputed products
    typedef struct packed {
        logic [TOL_BITS-1:0]  tol;
        logic [WIN_BITS-1:0]  tol_sq;
        logic [WIN_BITS-1:0]  persist;
        logic [CONF_BITS-1:0] persist_conf;
        logic [WIN_BITS-1:0]  settle;
        logic [WIN_BITS-1:0]  max_cross;
        logic [WIN_BITS-1:0]  obj_mem;
    } cfg_t;

endpackage

`default_nettype wire

>>> src/lane_crossing_event_classifier_unit.sv
// top level of the lane crossing event classifier: stream ports and pipeline registers
`default_nettype none

// The classifier takes one item per clock and gives exactly one result item
// for each. An item passes the input register and then the decision logic,
// which updates the classifier state and loads the result register at the
// same edge. The rate of one item per clock is set by that state update,
// which each item needs from the one before. Both sides may stall freely;
// when both registers hold an item, s_axis_tready follows m_axis_tready in
// the same cycle. A configuration write applies to every item decided after
// the write edge, including one accepted at that edge, so the user must make
// writes only while no item is held inside; the block does not enforce this.
module lane_crossing_event_classifier_unit #(
    parameter int TIME_BITS  = 32,
    parameter int COORD_BITS = 24
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration write port
    input  wire logic                             cfg_we,
    input  wire logic [lcec_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lcec_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input items
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // now_ms, crossing_seen, crossing_left, crossing_x_cm, crossing_y_cm,
    // object_qualifies, footprint_inside, full_entry, blinker
    input  wire logic [((TIME_BITS+2*COORD_BITS+7+7)/8)*8-1:0] s_axis_tdata,
    // result items
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // crossing_active, event_code
    output logic [lcec_pkg::OUT_W-1:0]            m_axis_tdata
);

    localparam int IN_BITS = TIME_BITS + 2 * COORD_BITS + 7;
    localparam int X_LO    = TIME_BITS + 2;
    localparam int Y_LO    = X_LO + COORD_BITS;
    localparam int F_LO    = Y_LO + COORD_BITS;

    lcec_pkg::cfg_t          cfg;
    logic                    in_valid_reg;
    logic [IN_BITS-1:0]      in_data_reg;
    logic                    out_valid_reg;
    logic                    out_active_reg;
    lcec_pkg::event_t        out_event_reg;
    logic                    step;
    logic                    active_next;
    lcec_pkg::event_t        event_next;

    // an item moves on when the result register is free or being emptied
    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_data_reg <= s_axis_tdata[IN_BITS-1:0];
        end
    end

    lcec_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lcec_core #(
        .TIME_BITS  (TIME_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step             (step),
        .now_ms           (in_data_reg[TIME_BITS-1:0]),
        .crossing_seen    (in_data_reg[TIME_BITS]),
        .crossing_left    (in_data_reg[TIME_BITS+1]),
        .crossing_x_cm    (in_data_reg[X_LO+COORD_BITS-1:X_LO]),
        .crossing_y_cm    (in_data_reg[Y_LO+COORD_BITS-1:Y_LO]),
        .object_qualifies (in_data_reg[F_LO]),
        .footprint_inside (in_data_reg[F_LO+1]),
        .full_entry       (in_data_reg[F_LO+2]),
        .blinker          (in_data_reg[F_LO+4:F_LO+3]),
        .cfg              (cfg),
        .active_next      (active_next),
        .event_next       (event_next)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_active_reg <= active_next;
            out_event_reg  <= event_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(lcec_pkg::OUT_W - lcec_pkg::EVENT_BITS - 1){1'b0}},
                            out_event_reg, out_active_reg};

endmodule

`default_nettype wire

>>> src/lcec_cfg.sv
// configuration registers and the products derived from them
`default_nettype none

module lcec_cfg (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [lcec_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lcec_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output lcec_pkg::cfg_t                        cfg
);

    logic [lcec_pkg::TOL_BITS-1:0]   tol_reg, tol_next;
    logic [lcec_pkg::WIN_BITS-1:0]   persist_reg, persist_next;
    logic [lcec_pkg::SCALE_BITS-1:0] scale_reg, scale_next;
    logic [lcec_pkg::WIN_BITS-1:0]   settle_reg, settle_next;
    logic [lcec_pkg::WIN_BITS-1:0]   max_cross_reg, max_cross_next;
    logic [lcec_pkg::WIN_BITS-1:0]   obj_mem_reg, obj_mem_next;
    logic [lcec_pkg::WIN_BITS-1:0]   tol_sq_reg;
    logic [lcec_pkg::CONF_BITS-1:0]  persist_conf_reg;

    logic [lcec_pkg::WIN_BITS+lcec_pkg::SCALE_BITS-1:0] persist_prod;

    // register writes, out of range indexes are dropped
    always_comb begin
        tol_next       = tol_reg;
        persist_next   = persist_reg;
        scale_next     = scale_reg;
        settle_next    = settle_reg;
        max_cross_next = max_cross_reg;
        obj_mem_next   = obj_mem_reg;
        if (cfg_we) begin
            case (cfg_index)
                lcec_pkg::REG_TOLERANCE: tol_next = cfg_wdata[lcec_pkg::TOL_BITS-1:0];
                lcec_pkg::REG_PERSIST:   persist_next = cfg_wdata[lcec_pkg::WIN_BITS-1:0];
                lcec_pkg::REG_SCALE:     scale_next = cfg_wdata[lcec_pkg::SCALE_BITS-1:0];
                lcec_pkg::REG_SETTLE:    settle_next = cfg_wdata[lcec_pkg::WIN_BITS-1:0];
                lcec_pkg::REG_MAX_CROSS: max_cross_next = cfg_wdata[lcec_pkg::WIN_BITS-1:0];
                lcec_pkg::REG_OBJ_MEM:   obj_mem_next = cfg_wdata[lcec_pkg::WIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg       <= lcec_pkg::TOL_RESET;
            persist_reg   <= lcec_pkg::PERSIST_RESET;
            scale_reg     <= lcec_pkg::SCALE_RESET;
            settle_reg    <= lcec_pkg::SETTLE_RESET;
            max_cross_reg <= lcec_pkg::MAX_CROSS_RESET;
            obj_mem_reg   <= lcec_pkg::OBJ_MEM_RESET;
        end else begin
            tol_reg       <= tol_next;
            persist_reg   <= persist_next;
            scale_reg     <= scale_next;
            settle_reg    <= settle_next;
            max_cross_reg <= max_cross_next;
            obj_mem_reg   <= obj_mem_next;
        end
    end

    // window scaled by the q8 confidence factor
    assign persist_prod = persist_next * scale_next;

    // products load at the same edge as the registers they come from
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_sq_reg       <= lcec_pkg::TOL_SQ_RESET;
            persist_conf_reg <= lcec_pkg::PERSIST_C_RESET;
        end else begin
            tol_sq_reg       <= tol_next * tol_next;
            persist_conf_reg <= persist_prod[lcec_pkg::WIN_BITS+lcec_pkg::SCALE_BITS-1:8];
        end
    end

    assign cfg.tol          = tol_reg;
    assign cfg.tol_sq       = tol_sq_reg;
    assign cfg.persist      = persist_reg;
    assign cfg.persist_conf = persist_conf_reg;
    assign cfg.settle       = settle_reg;
    assign cfg.max_cross    = max_cross_reg;
    assign cfg.obj_mem      = obj_mem_reg;

endmodule

`default_nettype wire

>>> src/lcec_core.sv
// classifier state and the single pass decision for one item
`default_nettype none

module lcec_core #(
    parameter int TIME_BITS  = 32,
    parameter int COORD_BITS = 24
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    step,
    input  wire logic [TIME_BITS-1:0]    now_ms,
    input  wire logic                    crossing_seen,
    input  wire logic                    crossing_left,
    input  wire logic [COORD_BITS-1:0]   crossing_x_cm,
    input  wire logic [COORD_BITS-1:0]   crossing_y_cm,
    input  wire logic                    object_qualifies,
    input  wire logic                    footprint_inside,
    input  wire logic                    full_entry,
    input  wire logic [1:0]              blinker,
    input  wire lcec_pkg::cfg_t          cfg,
    output logic                         active_next,
    output lcec_pkg::event_t             event_next
);

    localparam int CW = (TIME_BITS > lcec_pkg::CONF_BITS) ? TIME_BITS : lcec_pkg::CONF_BITS;
    localparam int DW = (COORD_BITS + 1 > lcec_pkg::TOL_BITS) ? COORD_BITS + 1
                                                              : lcec_pkg::TOL_BITS;
    localparam int TB = lcec_pkg::TOL_BITS;

    lcec_pkg::phase_t        phase_reg, phase_next;
    logic                    track_valid_reg, track_valid_next;
    logic                    track_left_reg, track_left_next;
    logic [COORD_BITS-1:0]   track_x_reg, track_x_next;
    logic [COORD_BITS-1:0]   track_y_reg, track_y_next;
    logic [TIME_BITS-1:0]    track_start_reg, track_start_next;
    logic                    ret_run_reg, ret_run_next;
    logic [TIME_BITS-1:0]    ret_start_reg, ret_start_next;
    logic                    obj_seen_reg, obj_seen_next;
    logic [TIME_BITS-1:0]    obj_last_reg, obj_last_next;
    logic [TIME_BITS-1:0]    commit_reg, commit_next;

    logic                    obj_seen_eff;
    logic [TIME_BITS-1:0]    obj_last_eff;
    logic [TIME_BITS-1:0]    obj_age;
    logic                    recent;
    logic [COORD_BITS:0]     dx_diff, dy_diff, dx_mag, dy_mag;
    logic [DW-1:0]           dx_w, dy_w;
    logic [TB-1:0]           dx_n, dy_n;
    logic [2*TB-1:0]         dx_sq, dy_sq;
    logic [2*TB:0]           sq_sum;
    logic                    near, match, conf;
    logic [TIME_BITS-1:0]    start_eff, track_age;
    logic [lcec_pkg::CONF_BITS-1:0] persist_eff;
    logic                    persist_done;
    logic [TIME_BITS-1:0]    ret_start_eff, ret_age, cross_age;
    logic                    settled, backstop;

    // object memory, refreshed by the current item
    assign obj_seen_eff = obj_seen_reg | object_qualifies;
    assign obj_last_eff = object_qualifies ? now_ms : obj_last_reg;
    assign obj_age      = now_ms - obj_last_eff;
    assign recent       = obj_seen_eff && (CW'(obj_age) <= CW'(cfg.obj_mem));

    // distance of the crossing point from the tracked one
    assign dx_diff = {crossing_x_cm[COORD_BITS-1], crossing_x_cm}
                   - {track_x_reg[COORD_BITS-1], track_x_reg};
    assign dy_diff = {crossing_y_cm[COORD_BITS-1], crossing_y_cm}
                   - {track_y_reg[COORD_BITS-1], track_y_reg};
    assign dx_mag  = dx_diff[COORD_BITS] ? (~dx_diff + 1'b1) : dx_diff;
    assign dy_mag  = dy_diff[COORD_BITS] ? (~dy_diff + 1'b1) : dy_diff;
    assign dx_w    = DW'(dx_mag);
    assign dy_w    = DW'(dy_mag);
    assign dx_n    = dx_w[TB-1:0];
    assign dy_n    = dy_w[TB-1:0];
    assign dx_sq   = dx_n * dx_n;
    assign dy_sq   = dy_n * dy_n;
    assign sq_sum  = {1'b0, dx_sq} + {1'b0, dy_sq};
    assign near    = (dx_w <= DW'(cfg.tol)) && (dy_w <= DW'(cfg.tol))
                   && (sq_sum <= {1'b0, cfg.tol_sq});
    assign match   = track_valid_reg && (track_left_reg == crossing_left) && near;

    // persistence check, window scaled by the confidence factor when the blinker agrees with the side
    assign conf         = crossing_left ? (blinker == lcec_pkg::BLINK_LEFT)
                                        : (blinker == lcec_pkg::BLINK_RIGHT);
    assign persist_eff  = conf ? cfg.persist_conf : lcec_pkg::CONF_BITS'(cfg.persist);
    assign start_eff    = match ? track_start_reg : now_ms;
    assign track_age    = now_ms - start_eff;
    assign persist_done = CW'(track_age) >= CW'(persist_eff);

    // settle and backstop timers of the crossing phase
    assign ret_start_eff = ret_run_reg ? ret_start_reg : now_ms;
    assign ret_age       = now_ms - ret_start_eff;
    assign settled       = footprint_inside && (CW'(ret_age) >= CW'(cfg.settle));
    assign cross_age     = now_ms - commit_reg;
    assign backstop      = CW'(cross_age) >= CW'(cfg.max_cross);

    // next state and event of this item
    always_comb begin
        phase_next       = phase_reg;
        track_valid_next = track_valid_reg;
        track_left_next  = track_left_reg;
        track_x_next     = track_x_reg;
        track_y_next     = track_y_reg;
        track_start_next = track_start_reg;
        ret_run_next     = ret_run_reg;
        ret_start_next   = ret_start_reg;
        obj_seen_next    = obj_seen_reg;
        obj_last_next    = obj_last_reg;
        commit_next      = commit_reg;
        event_next       = lcec_pkg::EV_NONE;
        case (phase_reg)
            lcec_pkg::PH_IDLE: begin
                obj_seen_next = obj_seen_eff;
                obj_last_next = obj_last_eff;
                if (!crossing_seen || !recent) begin
                    track_valid_next = 1'b0;
                end else begin
                    if (!match) begin
                        track_valid_next = 1'b1;
                        track_left_next  = crossing_left;
                        track_x_next     = crossing_x_cm;
                        track_y_next     = crossing_y_cm;
                        track_start_next = now_ms;
                    end
                    if (persist_done) begin
                        phase_next       = lcec_pkg::PH_CROSS;
                        commit_next      = now_ms;
                        track_valid_next = 1'b0;
                        ret_run_next     = 1'b0;
                        obj_seen_next    = 1'b0;
                        event_next       = lcec_pkg::EV_ONSET;
                    end
                end
            end
            lcec_pkg::PH_CROSS: begin
                if (full_entry) begin
                    event_next = lcec_pkg::EV_ABANDON;
                end else begin
                    ret_run_next = footprint_inside;
                    if (footprint_inside && !ret_run_reg) begin
                        ret_start_next = now_ms;
                    end
                    if (settled) begin
                        event_next = lcec_pkg::EV_RETURNED;
                    end else if (backstop) begin
                        event_next = lcec_pkg::EV_BACKSTOP;
                    end
                end
                if (event_next != lcec_pkg::EV_NONE) begin
                    phase_next       = lcec_pkg::PH_IDLE;
                    track_valid_next = 1'b0;
                    ret_run_next     = 1'b0;
                    obj_seen_next    = 1'b0;
                end
            end
            default: begin
                phase_next = lcec_pkg::PH_IDLE;
            end
        endcase
    end

    assign active_next = (phase_next == lcec_pkg::PH_CROSS);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= lcec_pkg::PH_IDLE;
            track_valid_reg <= 1'b0;
            ret_run_reg     <= 1'b0;
            obj_seen_reg    <= 1'b0;
        end else if (step) begin
            phase_reg       <= phase_next;
            track_valid_reg <= track_valid_next;
            ret_run_reg     <= ret_run_next;
            obj_seen_reg    <= obj_seen_next;
        end
    end

    // timestamps and tracked point, only read under their valid flags
    always_ff @(posedge aclk) begin
        if (step) begin
            track_left_reg  <= track_left_next;
            track_x_reg     <= track_x_next;
            track_y_reg     <= track_y_next;
            track_start_reg <= track_start_next;
            ret_start_reg   <= ret_start_next;
            obj_last_reg    <= obj_last_next;
            commit_reg      <= commit_next;
        end
    end

    // only onset can leave the idle phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && phase_reg == lcec_pkg::PH_IDLE && event_next != lcec_pkg::EV_NONE)
        |-> event_next == lcec_pkg::EV_ONSET)
        else $error("non-onset event raised in idle phase");

    // onset enters the crossing phase with a cleared track
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && event_next == lcec_pkg::EV_ONSET)
        |=> (phase_reg == lcec_pkg::PH_CROSS && !track_valid_reg && !obj_seen_reg))
        else $error("onset did not enter crossing phase cleanly");

    // any event in the crossing phase returns to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && phase_reg == lcec_pkg::PH_CROSS && event_next != lcec_pkg::EV_NONE)
        |=> (phase_reg == lcec_pkg::PH_IDLE && !ret_run_reg))
        else $error("crossing phase event did not return to idle");

endmodule

`default_nettype wire

>>> bench/lcec_event_checker.sv
// checker of the lane crossing event classifier: predicts each result item and compares it
`default_nettype none

module lcec_event_checker #(
    parameter int IN_W = 88
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [lcec_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lcec_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_axis_tvalid,
    input  wire logic                            s_axis_tready,
    // now_ms, crossing_seen, crossing_left, crossing_x_cm, crossing_y_cm,
    // object_qualifies, footprint_inside, full_entry, blinker
    input  wire logic [IN_W-1:0]                 s_axis_tdata,
    input  wire logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // crossing_active, event_code
    input  wire logic [lcec_pkg::OUT_W-1:0]      m_axis_tdata,
    output int                                   fail_count,
    output int                                   pending
);
    import lcec_pkg::*;

    typedef struct packed {
        logic                  active;
        logic [EVENT_BITS-1:0] code;
    } verdict_t;

    // register copies
    logic [TOL_BITS-1:0]   tol_cm;
    logic [WIN_BITS-1:0]   persist_ms;
    logic [SCALE_BITS-1:0] scale_q8;
    logic [WIN_BITS-1:0]   settle_ms;
    logic [WIN_BITS-1:0]   max_ms;
    logic [WIN_BITS-1:0]   objmem_ms;

    // classifier state
    logic        ph_cross;
    logic        trk_valid;
    logic        trk_left;
    logic [23:0] trk_x;
    logic [23:0] trk_y;
    logic [31:0] trk_start;
    logic        ret_run;
    logic [31:0] ret_start;
    logic        obj_seen;
    logic [31:0] obj_last;
    logic [31:0] commit_ms;

    // predicted result items, oldest first
    verdict_t verdict_q[$];

    initial fail_count = 0;
    initial pending = 0;

    // elapsed time, wraps modulo 2^32
    function automatic logic [31:0] ms_since(input logic [31:0] later,
                                             input logic [31:0] earlier);
        return later - earlier;
    endfunction

    // magnitude of the difference of two signed coordinates
    function automatic logic [63:0] coord_gap(input logic signed [23:0] a,
                                              input logic signed [23:0] b);
        logic signed [24:0] d;
        d = a - b;
        if (d < 0)
            d = -d;
        return {39'd0, d};
    endfunction

    // clears track, return timer and object memory
    function void drop_track();
        trk_valid = 1'b0;
        trk_left  = 1'b0;
        trk_x     = '0;
        trk_y     = '0;
        trk_start = '0;
        ret_run   = 1'b0;
        ret_start = '0;
        obj_seen  = 1'b0;
        obj_last  = '0;
    endfunction

    // one classifier step for an accepted item
    function void classify(input logic [IN_W-1:0] d, output verdict_t v);
        logic [31:0] now;
        logic        seen, lft, obj, fp_inside, entry;
        logic [23:0] x, y;
        logic [1:0]  blink;
        logic        recent, trk_match, conf, settled;
        logic [63:0] dx, dy, tol, eff;
        event_t      ev;
        now       = d[31:0];
        seen      = d[32];
        lft       = d[33];
        x         = d[57:34];
        y         = d[81:58];
        obj       = d[82];
        fp_inside = d[83];
        entry     = d[84];
        blink     = d[86:85];
        ev        = EV_NONE;
        if (!ph_cross) begin
            if (obj) begin
                obj_seen = 1'b1;
                obj_last = now;
            end
            recent = obj_seen && (ms_since(now, obj_last) <= objmem_ms);
            if (!seen || !recent) begin
                trk_valid = 1'b0;
            end else begin
                trk_match = 1'b0;
                conf = lft ? (blink == BLINK_LEFT) : (blink == BLINK_RIGHT);
                if (trk_valid && trk_left == lft) begin
                    dx  = coord_gap(x, trk_x);
                    dy  = coord_gap(y, trk_y);
                    tol = {48'd0, tol_cm};
                    if (dx <= tol && dy <= tol)
                        trk_match = (dx * dx + dy * dy) <= tol * tol;
                end
                // new crossing: restart the persistence timer
                if (!trk_match) begin
                    trk_valid = 1'b1;
                    trk_left  = lft;
                    trk_x     = x;
                    trk_y     = y;
                    trk_start = now;
                end
                eff = conf ? (({32'd0, persist_ms} * {55'd0, scale_q8}) >> 8)
                           : {32'd0, persist_ms};
                if ({32'd0, ms_since(now, trk_start)} >= eff) begin
                    ph_cross  = 1'b1;
                    commit_ms = now;
                    drop_track();
                    ev = EV_ONSET;
                end
            end
        end else begin
            if (entry) begin
                ev = EV_ABANDON;
            end else begin
                settled = 1'b0;
                if (!fp_inside) begin
                    ret_run = 1'b0;
                end else begin
                    if (!ret_run) begin
                        ret_run   = 1'b1;
                        ret_start = now;
                    end
                    settled = ms_since(now, ret_start) >= settle_ms;
                end
                if (settled)
                    ev = EV_RETURNED;
                else if (ms_since(now, commit_ms) >= max_ms)
                    ev = EV_BACKSTOP;
            end
            if (ev != EV_NONE) begin
                ph_cross = 1'b0;
                drop_track();
            end
        end
        v.active = ph_cross;
        v.code   = ev;
    endfunction

    // watch both channels and the register port
    always @(posedge aclk) begin : watch
        verdict_t want;
        verdict_t got;
        if (!aresetn) begin
            tol_cm     = TOL_RESET;
            persist_ms = PERSIST_RESET;
            scale_q8   = SCALE_RESET;
            settle_ms  = SETTLE_RESET;
            max_ms     = MAX_CROSS_RESET;
            objmem_ms  = OBJ_MEM_RESET;
            ph_cross   = 1'b0;
            commit_ms  = '0;
            drop_track();
            verdict_q.delete();
            pending <= 0;
        end else begin
            // compare a result item with the oldest prediction
            if (m_axis_tvalid && m_axis_tready) begin
                got.active = m_axis_tdata[0];
                got.code   = m_axis_tdata[3:1];
                if (verdict_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unpredicted result item: active %0d event %0d",
                                 got.active, got.code);
                end else begin
                    want = verdict_q.pop_front();
                    if (want.active !== got.active || want.code !== got.code) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: want active %0d event %0d, got active %0d event %0d",
                                     want.active, want.code, got.active, got.code);
                    end
                end
            end
            // register writes, bits above the register width dropped
            if (cfg_we) begin
                case (cfg_index)
                    REG_TOLERANCE: tol_cm     = cfg_wdata[TOL_BITS-1:0];
                    REG_PERSIST:   persist_ms = cfg_wdata[WIN_BITS-1:0];
                    REG_SCALE:     scale_q8   = cfg_wdata[SCALE_BITS-1:0];
                    REG_SETTLE:    settle_ms  = cfg_wdata[WIN_BITS-1:0];
                    REG_MAX_CROSS: max_ms     = cfg_wdata[WIN_BITS-1:0];
                    REG_OBJ_MEM:   objmem_ms  = cfg_wdata[WIN_BITS-1:0];
                    default: ;
                endcase
            end
            // predict the result of an accepted item
            if (s_axis_tvalid && s_axis_tready) begin
                classify(s_axis_tdata, want);
                verdict_q.push_back(want);
            end
            pending <= verdict_q.size();
        end
    end

endmodule

`default_nettype wire

>>> bench/tb_lane_crossing_event_classifier_unit.sv
// testbench top of the lane crossing event classifier: stimulus, stalls and verdict
`default_nettype none

module tb_lane_crossing_event_classifier_unit;
    import lcec_pkg::*;

    localparam int TIME_BITS   = 32;
    localparam int COORD_BITS  = 24;
    localparam int IN_W        = ((TIME_BITS + 2 * COORD_BITS + 7 + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD   = 400;
    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                  aclk;
    logic                  aresetn       = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;

    int          fail_count;
    int          pending;
    int          send_idle   = 0;
    int          recv_idle   = 0;
    int          hold_req    = 0;
    int          hold_served = 0;
    int          hold_left   = 0;
    int          items_sent  = 0;
    int          cycle_cnt   = 0;
    int          step_max    = 50;
    int          cur_tol     = 100;
    logic [31:0] clock_ms    = '0;

    lane_crossing_event_classifier_unit #(
        .TIME_BITS (TIME_BITS),
        .COORD_BITS(COORD_BITS)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    lcec_event_checker #(
        .IN_W(IN_W)
    ) u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // result side: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_served != hold_req) begin
            hold_served++;
            hold_left = LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    function automatic logic coin(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic logic [23:0] rnd24();
        logic [31:0] r;
        r = $urandom;
        return r[23:0];
    endfunction

    function automatic logic [1:0] rnd_blink();
        logic [31:0] r;
        r = $urandom_range(3);
        return r[1:0];
    endfunction

    // offer one item, with random gaps before it
    task automatic send_item(input logic [IN_W-1:0] d);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        items_sent++;
    endtask

    // pack the fields, lowest first
    task automatic send_fields(input logic [31:0] now, input logic seen, input logic lft,
                               input logic [23:0] x, input logic [23:0] y,
                               input logic obj, input logic fp_inside,
                               input logic entry, input logic [1:0] blink);
        send_item({1'b0, blink, entry, fp_inside, obj, y, x, lft, seen, now});
    endtask

    // stop offering until every predicted result item has come
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // one setting of the registers, then random traffic under it
    task automatic run_phase(input logic [31:0] tol, input logic [31:0] persist,
                             input logic [31:0] scale, input logic [31:0] settle,
                             input logic [31:0] maxc, input logic [31:0] objmem,
                             input int step, input int n);
        int target, half, ntrack, ncross, nnoise, i, jit, jx, jy;
        logic [23:0] bx, by;
        logic lft;
        logic [1:0] blink;
        drain_results();
        repeat (3) @(posedge aclk);
        cfg_write(REG_TOLERANCE, tol);
        cfg_write(REG_PERSIST, persist);
        cfg_write(REG_SCALE, scale);
        cfg_write(REG_SETTLE, settle);
        cfg_write(REG_MAX_CROSS, maxc);
        cfg_write(REG_OBJ_MEM, objmem);
        cfg_we <= 1'b0;
        repeat (3) @(posedge aclk);
        cur_tol  = int'(tol[15:0]);
        step_max = step;
        for (half = 0; half < 2; half++) begin
            target = items_sent + n / 2;
            while (items_sent < target) begin
                if (coin(75)) begin
                    // tracked crossing near one point, then crossing behavior
                    bx     = rnd24();
                    by     = rnd24();
                    lft    = coin(50);
                    ntrack = $urandom_range(2, 14);
                    for (i = 0; i < ntrack; i++) begin
                        clock_ms += $urandom_range(0, step_max);
                        jit = coin(15) ? cur_tol + int'($urandom_range(0, 200)) : cur_tol / 2;
                        jx  = int'($urandom_range(0, 2 * jit)) - jit;
                        jy  = int'($urandom_range(0, 2 * jit)) - jit;
                        if (coin(60))
                            blink = lft ? BLINK_LEFT : BLINK_RIGHT;
                        else
                            blink = rnd_blink();
                        send_fields(clock_ms, !coin(5), lft, bx + jx[23:0], by + jy[23:0],
                                    (i == 0) || coin(25), coin(50), coin(10), blink);
                    end
                    ncross = coin(10) ? $urandom_range(25, 60) : $urandom_range(2, 20);
                    for (i = 0; i < ncross; i++) begin
                        clock_ms += $urandom_range(0, step_max);
                        send_fields(clock_ms, coin(50), coin(50), rnd24(), rnd24(),
                                    coin(50), coin(90), coin(3), rnd_blink());
                    end
                end else begin
                    // noise, with timestamp jumps
                    nnoise = $urandom_range(1, 6);
                    for (i = 0; i < nnoise; i++) begin
                        if (coin(20))
                            clock_ms = $urandom;
                        else
                            clock_ms += $urandom_range(0, step_max);
                        send_fields(clock_ms, coin(50), coin(50), rnd24(), rnd24(),
                                    coin(50), coin(50), coin(50), rnd_blink());
                    end
                end
            end
            drain_results();
        end
    endtask

    // reset, directed items, then phases of random traffic
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        send_idle = 21;
        recv_idle = 50;

        // directed items under the reset values of the registers
        send_fields(32'd0, 1'b0, 1'b0, 24'd0, 24'd0, 1'b0, 1'b0, 1'b0, BLINK_NONE);
        // extreme coordinates, blinker agrees: window halved
        send_fields(32'd100, 1'b1, 1'b1, 24'h7FFFFF, 24'h800000, 1'b1, 1'b0, 1'b0, BLINK_LEFT);
        // drift exactly on the tolerance circle
        send_fields(32'd200, 1'b1, 1'b1, 24'h7FFFC3, 24'h800050, 1'b0, 1'b0, 1'b0, BLINK_LEFT);
        send_fields(32'd350, 1'b1, 1'b1, 24'h7FFFFF, 24'h800000, 1'b0, 1'b0, 1'b0, BLINK_LEFT);
        // settle inside the reference lanes
        send_fields(32'd400, 1'b0, 1'b0, 24'd0, 24'd0, 1'b0, 1'b1, 1'b0, BLINK_NONE);
        send_fields(32'd1400, 1'b0, 1'b0, 24'd0, 24'd0, 1'b0, 1'b1, 1'b0, BLINK_NONE);
        // within the box on both axes but outside the circle
        send_fields(32'd1500, 1'b1, 1'b0, 24'hFFFFFF, 24'd1, 1'b1, 1'b0, 1'b0, BLINK_RIGHT);
        send_fields(32'd1600, 1'b1, 1'b0, 24'd70, 24'd72, 1'b0, 1'b0, 1'b0, BLINK_RIGHT);
        send_fields(32'd1850, 1'b1, 1'b0, 24'd70, 24'd72, 1'b0, 1'b0, 1'b0, BLINK_RIGHT);
        // full entry abandons
        send_fields(32'd1900, 1'b0, 1'b0, 24'd0, 24'd0, 1'b0, 1'b1, 1'b1, BLINK_NONE);
        // blinker off, none, and pointing away: full window
        send_fields(32'd2000, 1'b1, 1'b1, 24'd0, 24'd0, 1'b1, 1'b0, 1'b0, BLINK_OFF);
        send_fields(32'd2499, 1'b1, 1'b1, 24'd0, 24'd0, 1'b0, 1'b0, 1'b0, BLINK_NONE);
        send_fields(32'd2500, 1'b1, 1'b1, 24'd0, 24'd0, 1'b0, 1'b0, 1'b0, BLINK_RIGHT);
        // backstop at the maximum duration
        send_fields(32'd12499, 1'b0, 1'b0, 24'd0, 24'd0, 1'b0, 1'b0, 1'b0, BLINK_NONE);
        send_fields(32'd12500, 1'b0, 1'b0, 24'd0, 24'd0, 1'b0, 1'b1, 1'b0, BLINK_NONE);
        // object memory cleared, then expired
        send_fields(32'd12600, 1'b1, 1'b0, 24'd0, 24'd0, 1'b0, 1'b0, 1'b0, BLINK_RIGHT);
        send_fields(32'd12700, 1'b0, 1'b0, 24'd0, 24'd0, 1'b1, 1'b0, 1'b0, BLINK_NONE);
        send_fields(32'd15000, 1'b1, 1'b0, 24'd0, 24'd0, 1'b0, 1'b0, 1'b0, BLINK_RIGHT);
        // timestamp going backwards looks like a long time
        send_fields(32'd15001, 1'b1, 1'b0, 24'd100, 24'd100, 1'b1, 1'b0, 1'b0, BLINK_RIGHT);
        send_fields(32'd10, 1'b1, 1'b0, 24'd100, 24'd100, 1'b1, 1'b0, 1'b0, BLINK_NONE);
        send_fields(32'd20, 1'b0, 1'b0, 24'd0, 24'd0, 1'b0, 1'b0, 1'b0, BLINK_NONE);
        send_fields(32'd5, 1'b0, 1'b0, 24'd0, 24'd0, 1'b0, 1'b0, 1'b0, BLINK_NONE);
        // idle ignores footprint flags
        send_fields(32'hFFFFFFF0, 1'b0, 1'b0, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1, 1'b1,
                    BLINK_RIGHT);
        // far apart extreme points never match
        send_fields(32'hFFFFFFF8, 1'b1, 1'b1, 24'h800000, 24'h7FFFFF, 1'b1, 1'b0, 1'b0,
                    BLINK_LEFT);
        send_fields(32'hFFFFFFFF, 1'b1, 1'b1, 24'h7FFFFF, 24'h800000, 1'b0, 1'b0, 1'b0,
                    BLINK_LEFT);

        // writes to indexes with no register are ignored
        drain_results();
        repeat (3) @(posedge aclk);
        cfg_write(REG_SPARE_LO, 32'hFFFFFFFF);
        cfg_write(REG_SPARE_HI, 32'h00000000);
        cfg_we <= 1'b0;
        clock_ms = 32'd1000;

        // sender idles less than receiver
        run_phase(32'd100, 32'd300, 32'd64, 32'd400, 32'd3000, 32'd1000, 60, 300);
        run_phase(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 3, 150);
        run_phase(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFF00, 32'hFFFFFFFF,
                  32'hFFFFFFFF, 32'hFFFFFFFF, 2000, 100);
        // receiver idles less than sender
        send_idle = 50;
        recv_idle = 21;
        run_phase(32'd1000, 32'd1000, 32'h1FF, 32'd200, 32'd5000, 32'd500, 150, 250);
        run_phase(32'd20, 32'd200, 32'd256, 32'd1500, 32'd600, 32'd300, 80, 250);
        // no idling; one long hold-off fills the block
        send_idle = 0;
        recv_idle = 0;
        hold_req  = hold_req + 1;
        run_phase($urandom_range(0, 300), $urandom_range(0, 800), $urandom_range(0, 511),
                  $urandom_range(0, 1000), $urandom_range(0, 4000), $urandom_range(0, 2000),
                  100, 250);
        run_phase({16'd0, TOL_RESET}, PERSIST_RESET, {23'd0, SCALE_RESET}, SETTLE_RESET,
                  MAX_CROSS_RESET, OBJ_MEM_RESET, 100, 200);

        drain_results();
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
